/* rtl/ukvt_pkg.sv */
// shared constants and codes for the unsorted key/value table
package ukvt_pkg;

  localparam int DEPTH      = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

endpackage

/* rtl/ukvt_ram.sv */
// generic single-write, single-read ram with registered read data
module ukvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/unsorted_key_value_table.sv */
// unsorted key/value table: records appended at the end, linear search in ram
//
// usage: a transaction is taken on the rising edge where start is high and
//   busy is low; command, key and value are sampled there. each transaction
//   gives exactly one result: done is high for one cycle with status,
//   found_value and entry_count valid in that same cycle.
// insert: the record is written on the accept edge; done is high in the next
//   cycle and busy stays low, so inserts run one per cycle. an insert into a
//   full table is dropped with status full. the unused command code is a no-op
//   with the same timing.
// find/delete: the ram is scanned one entry per cycle with registered read
//   data, ending early on a hit. a delete that hits then reads the last
//   record in READ_LAST and writes it over the hit slot in MOVE. the scan
//   loop over the ram read port sets the pace; the worst case is a delete
//   that hits the last entry of a full table.
// busy is high from the cycle after accept until the result cycle; a new
//   start is taken in the result cycle itself.
// reset: rst (synchronous, active high) empties the table at once; ram
//   contents are not cleared, entries beyond the count are never compared.
// the receiver cannot stall: each result is presented for one cycle only.
module unsorted_key_value_table
  import ukvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  done,
  output logic [1:0]            status,
  output logic [VALUE_BITS-1:0] found_value,
  output logic [COUNT_BITS-1:0] entry_count
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    READ_LAST,
    MOVE
  } state_t;

  state_t                state;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] iss;        // next entry to read during a scan
  logic                  chk_valid;  // read data of chk_idx arrives this cycle
  logic [ADDR_BITS-1:0]  chk_idx;
  logic [ADDR_BITS-1:0]  match_idx;
  logic                  is_find;
  logic [KEY_BITS-1:0]   key_r;

  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;
  logic [ADDR_BITS-1:0]  mem_raddr;
  logic [ENTRY_BITS-1:0] mem_rdata;

  logic [COUNT_BITS-1:0] last_count;
  logic                  accept;
  logic                  full;
  logic                  hit;

  assign busy       = (state != IDLE);
  assign accept     = start && !busy;
  assign full       = (count == COUNT_BITS'(DEPTH));
  assign last_count = count - COUNT_BITS'(1);
  // compare the key half of the entry that the ram returns this cycle
  assign hit        = chk_valid && (mem_rdata[ENTRY_BITS-1:VALUE_BITS] == key_r);

  // write port: appends on insert, moves the last record on delete
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[ADDR_BITS-1:0];
    mem_wdata = {key, value};
    if (accept && command == CMD_INSERT && !full) begin
      mem_we = 1'b1;
    end else if (state == MOVE) begin
      mem_we    = 1'b1;
      mem_waddr = match_idx;
      mem_wdata = mem_rdata;
    end
  end

  // read port: scan pointer, or the last record before a move
  always_comb begin
    if (state == READ_LAST) begin
      mem_raddr = last_count[ADDR_BITS-1:0];
    end else begin
      mem_raddr = iss[ADDR_BITS-1:0];
    end
  end

  ukvt_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      done      <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            key_r       <= key;
            is_find     <= (command == CMD_FIND);
            iss         <= '0;
            chk_valid   <= 1'b0;
            found_value <= '0;
            status      <= ST_DONE;
            entry_count <= count;
            case (command) inside
              CMD_INSERT: begin
                done <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  count       <= count + COUNT_BITS'(1);
                  entry_count <= count + COUNT_BITS'(1);
                end
              end
              CMD_DELETE, CMD_FIND: begin
                state <= SCAN;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        SCAN: begin
          if (hit) begin
            chk_valid <= 1'b0;
            if (is_find) begin
              done        <= 1'b1;
              status      <= ST_DONE;
              found_value <= mem_rdata[VALUE_BITS-1:0];
              entry_count <= count;
              state       <= IDLE;
            end else begin
              match_idx <= chk_idx;
              state     <= READ_LAST;
            end
          end else if (!chk_valid && iss == count) begin
            done        <= 1'b1;
            status      <= ST_MISSING;
            found_value <= '0;
            entry_count <= count;
            state       <= IDLE;
          end else begin
            chk_valid <= (iss < count);
            chk_idx   <= iss[ADDR_BITS-1:0];
            if (iss < count) begin
              iss <= iss + COUNT_BITS'(1);
            end
          end
        end
        READ_LAST: begin
          state <= MOVE;
        end
        MOVE: begin
          count       <= last_count;
          done        <= 1'b1;
          status      <= ST_DONE;
          found_value <= '0;
          entry_count <= last_count;
          state       <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(DEPTH))
    else $error("entry count above capacity");

  // a full report only comes with a full table
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> entry_count == COUNT_BITS'(DEPTH))
    else $error("full status with room left");

  // found_value is zero unless the operation succeeded
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_DONE |-> found_value == '0)
    else $error("found value on failed operation");

  // the scan only compares entries below the count
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == SCAN && chk_valid |-> {1'b0, chk_idx} < count)
    else $error("scan compared an entry beyond the count");
`endif

endmodule

/* bench/ukvt_checker.sv */
// result checker for the unsorted key/value table: shadow table and reply queue
`timescale 1ns / 100ps

module ukvt_checker
  import ukvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            command,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  done,
  input  logic [1:0]            status,
  input  logic [VALUE_BITS-1:0] found_value,
  input  logic [COUNT_BITS-1:0] entry_count,
  output int                    errors,
  output int                    pending,
  output int                    checked,
  output int                    full_seen
);

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] found_value;
    logic [COUNT_BITS-1:0] entry_count;
  } table_reply_t;

  table_reply_t          replies_due[$];
  table_reply_t          due;
  logic [KEY_BITS-1:0]   shadow_keys   [DEPTH];
  logic [VALUE_BITS-1:0] shadow_values [DEPTH];
  int                    shadow_count;

  function automatic int first_key_slot(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_keys[i] == k) return i;
    return -1;
  endfunction

  // applies one transaction to the shadow table and returns the reply it causes
  function automatic table_reply_t update_shadow_table(logic [1:0] cmd,
                                                       logic [KEY_BITS-1:0] k,
                                                       logic [VALUE_BITS-1:0] v);
    table_reply_t r;
    int           slot;
    r.status      = ST_DONE;
    r.found_value = '0;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
          full_seen++;
        end else begin
          shadow_keys[shadow_count]   = k;
          shadow_values[shadow_count] = v;
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        slot = first_key_slot(k);
        if (slot < 0) begin
          r.status = ST_MISSING;
        end else begin
          // last record fills the hole
          shadow_keys[slot]   = shadow_keys[shadow_count-1];
          shadow_values[slot] = shadow_values[shadow_count-1];
          shadow_count--;
        end
      end
      CMD_FIND: begin
        slot = first_key_slot(k);
        if (slot < 0) r.status = ST_MISSING;
        else r.found_value = shadow_values[slot];
      end
      default: ;
    endcase
    r.entry_count = COUNT_BITS'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      replies_due.delete();
    end else begin
      // a result is compared before the transaction taken at the same edge
      if (done) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected result", 64'({status, found_value}), '0);
        end else begin
          due = replies_due.pop_front();
          checked++;
          if (status !== due.status)
            report_mismatch("status", 64'(status), 64'(due.status));
          if (found_value !== due.found_value)
            report_mismatch("found_value", 64'(found_value), 64'(due.found_value));
          if (entry_count !== due.entry_count)
            report_mismatch("entry_count", 64'(entry_count), 64'(due.entry_count));
        end
      end
      if (start && !busy)
        replies_due = {replies_due, update_shadow_table(command, key, value)};
    end
    pending <= replies_due.size();
  end

endmodule

/* bench/unsorted_key_value_table_tb.sv */
// testbench top for the unsorted key/value table: stimulus, clock, reset, verdict
`timescale 1ns / 100ps

module unsorted_key_value_table_tb;
  import ukvt_pkg::*;

  localparam int RANDOM_ITEMS  = 1500;
  localparam int QUIET_FROM    = 1200;      // no idling from here to the end
  localparam int SEGMENT       = 100;       // random items per traffic mix
  localparam int POOL_SIZE     = 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = DEPTH + 8; // worst scan plus delete move

  logic                  clk;
  logic                  rst   = 1'b1;
  logic                  start = 1'b0;
  logic [1:0]            command = CMD_INSERT;
  logic [KEY_BITS-1:0]   key   = '0;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  busy;
  logic                  done;
  logic [1:0]            status;
  logic [VALUE_BITS-1:0] found_value;
  logic [COUNT_BITS-1:0] entry_count;

  int errors, pending, checked, full_seen;

  // small key set so that deletes and finds actually hit, and duplicates pile up
  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
  int                  sent_by_cmd [4];
  int                  cycles;

  unsorted_key_value_table uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .key         (key),
    .value       (value),
    .done        (done),
    .status      (status),
    .found_value (found_value),
    .entry_count (entry_count)
  );

  ukvt_checker table_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .key         (key),
    .value       (value),
    .done        (done),
    .status      (status),
    .found_value (found_value),
    .entry_count (entry_count),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked),
    .full_seen   (full_seen)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
    $display("** unsorted_key_value_table: FAILED **");
    $finish;
  end

  // one transaction: start stays up until the edge where busy is low
  task automatic send_item(logic [1:0] cmd, logic [KEY_BITS-1:0] k,
                           logic [VALUE_BITS-1:0] v);
    start   <= 1'b1;
    command <= cmd;
    key     <= k;
    value   <= v;
    sent_by_cmd[cmd]++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender gap; the payload wanders meanwhile so stale sampling shows up
  task automatic idle_for(int n);
    start   <= 1'b0;
    command <= 2'($urandom);
    key     <= $urandom;
    value   <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every reply has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key(int hit_pct);
    if ($urandom_range(99) < hit_pct) return key_pool[$urandom_range(POOL_SIZE-1)];
    return $urandom;
  endfunction

  // traffic mix per segment: fill, drain or balanced
  function automatic logic [1:0] pick_command(int mix);
    int roll;
    int ins_pct, del_pct, find_pct;
    roll = $urandom_range(99);
    case (mix)
      0:       begin ins_pct = 70; del_pct = 10; find_pct = 15; end
      1:       begin ins_pct = 10; del_pct = 65; find_pct = 20; end
      default: begin ins_pct = 35; del_pct = 30; find_pct = 30; end
    endcase
    if (roll < ins_pct) return CMD_INSERT;
    if (roll < ins_pct + del_pct) return CMD_DELETE;
    if (roll < ins_pct + del_pct + find_pct) return CMD_FIND;
    return CMD_UNUSED; // answered as a no-op
  endfunction

  initial begin
    logic [1:0] cmd;
    int         mix;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-table misses, unused code, extremes, duplicates,
    // delete that moves the last record, delete of the last record itself
    send_item(CMD_FIND,   32'h0000_0005, 32'hdead_beef);
    send_item(CMD_DELETE, 32'h0000_0005, '0);
    send_item(CMD_UNUSED, '1,            '1);
    send_item(CMD_INSERT, '0,            '1);
    send_item(CMD_INSERT, '1,            '0);
    send_item(CMD_INSERT, '0,            32'h0000_1234);
    send_item(CMD_INSERT, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    send_item(CMD_FIND,   '0,            '0);          // first duplicate wins
    send_item(CMD_FIND,   '1,            '1);
    send_item(CMD_FIND,   32'h1234_5678, '1);          // absent key
    send_item(CMD_DELETE, '0,            '1);          // last record moves to slot 0
    send_item(CMD_FIND,   '0,            '0);          // now the second duplicate
    send_item(CMD_FIND,   32'ha5a5_a5a5, '0);
    send_item(CMD_DELETE, '1,            '0);
    send_item(CMD_DELETE, '1,            '0);          // already gone
    send_item(CMD_DELETE, '0,            '0);
    send_item(CMD_DELETE, 32'ha5a5_a5a5, '0);          // only record left
    send_item(CMD_UNUSED, '0,            '0);
    send_item(CMD_FIND,   '0,            '0);          // empty again
    wait_drained();

    // random: segments alternate the mix so the table fills past full and drains
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      mix = (i / SEGMENT) % 3;
      if (i == RANDOM_ITEMS / 2) wait_drained();
      // every fourth segment and the tail run back to back
      if (i < QUIET_FROM && (i / SEGMENT) % 4 != 3 && $urandom_range(4) == 0)
        idle_for($urandom_range(1, 16));
      cmd = pick_command(mix);
      case (cmd) inside
        CMD_INSERT: send_item(cmd, pick_key(97), $urandom);
        CMD_DELETE,
        CMD_FIND:   send_item(cmd, pick_key(85), $urandom);
        default:    send_item(cmd, $urandom, $urandom);
      endcase
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d transactions: %0d insert, %0d delete, %0d find, %0d unused code",
             sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
             sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_DELETE], sent_by_cmd[CMD_FIND],
             sent_by_cmd[CMD_UNUSED]);
    $display("%0d results compared, %0d inserts turned away by a full table",
             checked, full_seen);
    if (errors == 0) begin
      $display("** unsorted_key_value_table: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** unsorted_key_value_table: FAILED **");
    end
    $finish;
  end

endmodule
